/* rtl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, idle while reset is held
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, idle while reset is held
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pcbp_pkg.sv */
// Shared types and constants of the prefixed code bit packer
package pcbp_pkg;

    // Default packing word width
    localparam int WORD_BITS_DEF = 64;

    // Fixed field widths of the channels
    localparam int OP_W    = 2;
    localparam int VALUE_W = 16;
    localparam int OUT_W   = 64;
    localparam int COUNT_W = 7;
    localparam int CODE_W  = 19;
    localparam int LEN_W   = 5;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WORD  = 2'd0;
    localparam logic [OP_W-1:0] OP_LIT   = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // Code lengths and prefixes
    localparam logic [LEN_W-1:0]  CODE_LONG_LEN  = 5'd19;
    localparam logic [LEN_W-1:0]  CODE_SHORT_LEN = 5'd9;
    localparam logic [CODE_W-1:0] PREFIX_CAP     = 19'h60000;
    localparam logic [CODE_W-1:0] PREFIX_LOW     = 19'h40000;

    typedef logic [OUT_W-1:0]   t_word;
    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic {
        K_PUSH,
        K_FLUSH
    } t_kind;

    // One classified entry travelling from front to back
    typedef struct packed {
        t_kind              kind;
        logic [CODE_W-1:0]  code;
        logic [LEN_W-1:0]   len;
    } t_entry;

endpackage

/* rtl/pcbp_if.sv */
// Valid/ready channel interfaces for items and packed words
interface pcbp_in_if;
    import pcbp_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic               capital;

    modport source (output valid, output op, output value, output capital, input ready);
    modport sink   (input valid, input op, input value, input capital, output ready);
endinterface

interface pcbp_out_if;
    import pcbp_pkg::*;

    logic   valid;
    logic   ready;
    t_word  packed_word;
    t_count bit_count;
    logic   is_final;

    modport source (output valid, output packed_word, output bit_count, output is_final,
                    input ready);
    modport sink   (input valid, input packed_word, input bit_count, input is_final,
                    output ready);
endinterface

/* rtl/pcbp_front.sv */
// Front end: accept items and turn them into codes or flush requests
module pcbp_front (
    pcbp_in_if.sink           i_in,
    input  logic              i_full,
    output logic              o_push,
    output pcbp_pkg::t_entry  o_entry
);
    import pcbp_pkg::*;

    logic take;

    // Accept whenever the queue has room
    assign i_in.ready = !i_full;
    assign take       = i_in.valid && !i_full;

    // Classify the item; an unused op is taken and dropped
    always_comb begin
        o_push        = 1'b0;
        o_entry.kind  = K_PUSH;
        o_entry.code  = '0;
        o_entry.len   = CODE_SHORT_LEN;
        case (i_in.op)
            OP_WORD: begin
                o_push       = take;
                o_entry.code = (i_in.capital ? PREFIX_CAP : PREFIX_LOW)
                               | CODE_W'(i_in.value);
                o_entry.len  = CODE_LONG_LEN;
            end
            OP_LIT: begin
                o_push       = take;
                o_entry.code = CODE_W'(i_in.value[7:0]);
                o_entry.len  = CODE_SHORT_LEN;
            end
            OP_FLUSH: begin
                o_push       = take;
                o_entry.kind = K_FLUSH;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end
endmodule

/* rtl/pcbp_fifo.sv */
// Short queue of classified entries between front and back
module pcbp_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pcbp_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output pcbp_pkg::t_entry  o_entry
);
    import pcbp_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

/* rtl/pcbp_back.sv */
// Back end: shift codes into the accumulator and register finished words
module pcbp_back #(
    parameter int WORD_BITS = pcbp_pkg::WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  pcbp_pkg::t_entry  i_entry,
    output logic              o_pop,
    pcbp_out_if.source        o_out
);
    import pcbp_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] r_acc;
    logic [CNT_W-1:0]     r_fill;
    logic                 r_valid;
    t_word                r_word;
    t_count               r_count;
    logic                 r_final;

    logic [WORD_BITS-1:0] n_acc;
    logic [CNT_W-1:0]     n_fill;
    logic                 emit;
    logic [WORD_BITS-1:0] emit_word;
    logic [CNT_W-1:0]     emit_count;
    logic                 emit_final;

    logic [CNT_W-1:0]     room;
    logic [CNT_W-1:0]     len_x;
    logic [CNT_W-1:0]     over_x;
    logic [LEN_W-1:0]     over;
    logic [WORD_BITS-1:0] code_x;
    logic                 out_free;

    // Take the next entry when the output register is free or draining
    assign out_free = !r_valid || o_out.ready;
    assign o_pop    = !i_empty && out_free;

    assign room   = CNT_W'(WORD_BITS) - r_fill;
    assign len_x  = CNT_W'(i_entry.len);
    assign over_x = len_x - room;
    assign over   = over_x[LEN_W-1:0];
    assign code_x = WORD_BITS'(i_entry.code);

    // Merge a code, or drain the pending bits on a flush
    always_comb begin
        n_acc      = r_acc;
        n_fill     = r_fill;
        emit       = 1'b0;
        emit_word  = '0;
        emit_count = CNT_W'(WORD_BITS);
        emit_final = 1'b0;
        case (i_entry.kind)
            K_PUSH: begin
                if (len_x < room) begin
                    n_acc  = (r_acc << i_entry.len) | code_x;
                    n_fill = r_fill + len_x;
                end else begin
                    emit      = 1'b1;
                    emit_word = (r_acc << room) | (code_x >> over);
                    n_acc     = code_x & ((WORD_BITS'(1) << over) - WORD_BITS'(1));
                    n_fill    = CNT_W'(over);
                end
            end
            K_FLUSH: begin
                if (r_fill != '0) begin
                    emit       = 1'b1;
                    emit_word  = r_acc << (CNT_W'(WORD_BITS) - r_fill);
                    emit_count = r_fill;
                    emit_final = 1'b1;
                    n_acc      = '0;
                    n_fill     = '0;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Hold packer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_fill <= '0;
        end else if (o_pop) begin
            r_acc  <= n_acc;
            r_fill <= n_fill;
        end
    end

    // Output register: load on a finished word, drop once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_word  <= OUT_W'(emit_word);
            r_count <= COUNT_W'(emit_count);
            r_final <= emit_final;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.packed_word = r_word;
    assign o_out.bit_count   = r_count;
    assign o_out.is_final    = r_final;
endmodule

/* rtl/prefixed_code_bit_packer.sv */
// A word that an item completes is registered first in the queue and then in the output register.
// One item per cycle unless a stalled output fills the queue; the shift-and-merge is combinational per popped code.
// A two-entry queue parts the item side from the packer, so each side can stall on its own.
// A stalled output holds its word while the queue takes up to two more items.
// Reset (i_rst_n low, synchronous) empties the queue, the accumulator and the output register.
module prefixed_code_bit_packer #(
    parameter int WORD_BITS = pcbp_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcbp_in_if.sink     i_in,
    pcbp_out_if.source  o_out
);
    import pcbp_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry front_entry;
    t_entry queue_entry;

    // Classify incoming items
    pcbp_front u_front (
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (front_entry)
    );

    // Decouple front and back
    pcbp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_entry (queue_entry)
    );

    // Pack codes into words
    pcbp_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (queue_entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule

/* rtl/pcbp_checker.sv */
// Port-level checks of the packer output, bound to the top level
`include "assert_macros.svh"

module pcbp_checker #(
    parameter int WORD_BITS = pcbp_pkg::WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  pcbp_pkg::t_word     i_out_word,
    input  pcbp_pkg::t_count    i_out_count,
    input  logic                i_out_final
);
    import pcbp_pkg::*;

    localparam t_count FULL_CNT = COUNT_W'(WORD_BITS);

    // A stalled word holds
    `ASSERT_NXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word) && $stable(i_out_count) && $stable(i_out_final), "stalled word changed")

    // A filled word carries the full count
    `ASSERT_IMP(a_full_cnt, i_out_valid && !i_out_final, i_out_count == FULL_CNT, "filled word count wrong")

    // A flushed word carries a partial count
    `ASSERT_IMP(a_final_cnt, i_out_valid && i_out_final, i_out_count != '0 && i_out_count < FULL_CNT, "final word count out of range")

    // Bits above the word width stay clear
    `ASSERT_IMP(a_upper_zero, i_out_valid, (i_out_word >> WORD_BITS) == '0, "bits above word width set")
endmodule

bind prefixed_code_bit_packer pcbp_checker #(
    .WORD_BITS (WORD_BITS)
) u_pcbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.packed_word),
    .i_out_count (o_out.bit_count),
    .i_out_final (o_out.is_final)
);
